[rtl/dplru_pkg.sv]
// ----------------------------------------------------------------------------
// Demand paging LRU translator package
// Shared widths, result codes and the cell entry type.
// ----------------------------------------------------------------------------
package dplru_pkg;

  localparam int NUM_PAGES   = 8;
  localparam int NUM_FRAMES  = 4;
  localparam int OFFSET_BITS = 6;

  localparam int ADDR_W      = 16;
  localparam int PHYS_W      = 14;
  localparam int FRAME_W     = 8;
  localparam int EVICT_W     = 3;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int PAGE_FULL_W = ADDR_W - OFFSET_BITS;
  localparam int PAGE_IDX_W  = $clog2(NUM_PAGES);
  localparam int SLOT_W      = $clog2(NUM_FRAMES);
  localparam int USED_W      = $clog2(NUM_FRAMES + 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_HIT   = 2'd0,
    ST_FAULT = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic                  valid;
    logic [PAGE_IDX_W-1:0] page;
    logic [FRAME_W-1:0]    frame;
    logic                  dirty;
  } entry_t;

endpackage

[rtl/dplru_cell.sv]
// ----------------------------------------------------------------------------
// Demand paging LRU cell
// One recency position: holds a resident page, its frame and dirty bit, and
// takes the entry of its younger neighbor while the shift token passes it.
// ----------------------------------------------------------------------------
module dplru_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dplru_pkg::entry_t                   prev_i,
  input  logic                                shift_i,
  input  logic [dplru_pkg::PAGE_IDX_W-1:0]    page_i,
  output dplru_pkg::entry_t                   entry_o,
  output logic                                match_o,
  output logic                                shift_o
);
  import dplru_pkg::*;

  entry_t entry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else if (shift_i) begin
      entry_q <= prev_i;
    end
  end

  // The token stops at the matching entry or at the first empty position.
  assign match_o = entry_q.valid && (entry_q.page == page_i);
  assign shift_o = shift_i && entry_q.valid && !match_o;
  assign entry_o = entry_q;

endmodule

[rtl/demand_paging_lru_translate.sv]
// The input transfer loads the address register, then the result register
// loads once the output is free; a result is held while the output is stalled.
// Throughput: one access per cycle while the output is not stalled; the cell
// chain updates in the same cycle that the result register loads, so the
// next access sees the new order. Reset clears the cell chain and the fill
// count; frame registers reset to their slot numbers.
// ----------------------------------------------------------------------------
// Demand paging LRU translator
// Translates logical addresses through a row of recency cells, youngest
// first; a fault fills a free frame, or evicts the oldest resident page.
// ----------------------------------------------------------------------------
module demand_paging_lru_translate (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [dplru_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dplru_pkg::FRAME_W-1:0]        cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [dplru_pkg::ADDR_W-1:0]         logical_address_i,
  input  logic                                 is_store_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [dplru_pkg::STATUS_W-1:0]       status_o,
  output logic [dplru_pkg::PHYS_W-1:0]         physical_address_o,
  output logic [dplru_pkg::FRAME_W-1:0]        loaded_frame_o,
  output logic                                 evict_valid_o,
  output logic [dplru_pkg::EVICT_W-1:0]        evicted_page_o,
  output logic                                 writeback_needed_o
);
  import dplru_pkg::*;

  logic [FRAME_W-1:0]     frame_slot_q [NUM_FRAMES];
  logic [USED_W-1:0]      used_q, used_d;
  logic                   busy_q;
  logic [ADDR_W-1:0]      addr_q;
  logic                   store_q;

  logic                   out_valid_q;
  status_e                status_q, status_d;
  logic [PHYS_W-1:0]      phys_q, phys_d;
  logic [FRAME_W-1:0]     loaded_q, loaded_d;
  logic                   evict_q, evict_d;
  logic [EVICT_W-1:0]     evicted_q, evicted_d;
  logic                   wb_q, wb_d;

  logic                   exec;
  logic                   in_range;
  logic                   op;
  logic                   hit;
  logic                   evict;
  logic [PAGE_FULL_W-1:0] page_full;
  logic [PAGE_IDX_W-1:0]  qpage;
  logic [OFFSET_BITS-1:0] offset;
  entry_t                 hit_entry;
  entry_t                 new_entry;
  entry_t                 cells [NUM_FRAMES];
  entry_t                 prevs [NUM_FRAMES];
  logic [NUM_FRAMES-1:0]  match;
  logic [NUM_FRAMES:0]    shift;
  logic [FRAME_W+OFFSET_BITS-1:0] phys_full;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_FRAMES; i++) begin
        frame_slot_q[i] <= FRAME_W'(i);
      end
    end else if (cfg_valid_i && (int'(cfg_index_i) < NUM_FRAMES)) begin
      frame_slot_q[cfg_index_i[SLOT_W-1:0]] <= cfg_data_i;
    end
  end

  assign exec       = busy_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy_q || exec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      busy_q <= 1'b1;
    end else if (exec) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      addr_q  <= logical_address_i;
      store_q <= is_store_i;
    end
  end

  assign page_full = addr_q[ADDR_W-1:OFFSET_BITS];
  assign offset    = addr_q[OFFSET_BITS-1:0];
  assign in_range  = int'(page_full) < NUM_PAGES;
  assign qpage     = page_full[PAGE_IDX_W-1:0];
  assign op        = exec && in_range;

  assign shift[0] = op;

  for (genvar g = 0; g < NUM_FRAMES; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign prevs[g] = new_entry;
    end else begin : g_body
      assign prevs[g] = cells[g-1];
    end
    dplru_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .prev_i  (prevs[g]),
      .shift_i (shift[g]),
      .page_i  (qpage),
      .entry_o (cells[g]),
      .match_o (match[g]),
      .shift_o (shift[g+1])
    );
  end

  assign hit   = |match;
  assign evict = shift[NUM_FRAMES];

  always_comb begin
    hit_entry = '0;
    for (int i = 0; i < NUM_FRAMES; i++) begin
      hit_entry = hit_entry | (cells[i] & {$bits(entry_t){match[i]}});
    end
  end

  always_comb begin
    new_entry       = '0;
    new_entry.valid = 1'b1;
    new_entry.page  = qpage;
    new_entry.dirty = hit && (hit_entry.dirty || store_q);
    priority if (hit) begin
      new_entry.frame = hit_entry.frame;
    end else if (evict) begin
      new_entry.frame = cells[NUM_FRAMES-1].frame;
    end else begin
      new_entry.frame = frame_slot_q[used_q[SLOT_W-1:0]];
    end
  end

  always_comb begin
    used_d = used_q;
    if (op && !hit && !evict) begin
      used_d = used_q + USED_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  assign phys_full = {hit_entry.frame, offset};

  always_comb begin
    status_d  = ST_FAULT;
    phys_d    = '0;
    loaded_d  = '0;
    evict_d   = 1'b0;
    evicted_d = '0;
    wb_d      = 1'b0;
    priority if (!in_range) begin
      status_d = ST_RANGE;
    end else if (hit) begin
      status_d = ST_HIT;
      phys_d   = PHYS_W'(phys_full);
    end else begin
      loaded_d = new_entry.frame;
      if (evict) begin
        evict_d   = 1'b1;
        evicted_d = EVICT_W'(cells[NUM_FRAMES-1].page);
        wb_d      = cells[NUM_FRAMES-1].dirty;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (exec) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec) begin
      status_q  <= status_d;
      phys_q    <= phys_d;
      loaded_q  <= loaded_d;
      evict_q   <= evict_d;
      evicted_q <= evicted_d;
      wb_q      <= wb_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign physical_address_o = phys_q;
  assign loaded_frame_o     = loaded_q;
  assign evict_valid_o      = evict_q;
  assign evicted_page_o     = evicted_q;
  assign writeback_needed_o = wb_q;

endmodule

[rtl/dplru_checker.sv]
// ----------------------------------------------------------------------------
// Demand paging LRU translator checker
// Port-level checks on result consistency and the output transfer.
// ----------------------------------------------------------------------------
module dplru_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 out_valid_o,
  input logic                                 out_ready_i,
  input logic [dplru_pkg::STATUS_W-1:0]       status_o,
  input logic [dplru_pkg::PHYS_W-1:0]         physical_address_o,
  input logic [dplru_pkg::FRAME_W-1:0]        loaded_frame_o,
  input logic                                 evict_valid_o,
  input logic [dplru_pkg::EVICT_W-1:0]        evicted_page_o,
  input logic                                 writeback_needed_o
);
  import dplru_pkg::*;

  // A stalled result keeps its status and translation.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(physical_address_o) && $stable(evicted_page_o))
    else $error("stalled result changed");

  // An out-of-range access carries nothing else.
  a_range_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_RANGE) |-> (physical_address_o == '0)
      && (loaded_frame_o == '0) && !evict_valid_o && !writeback_needed_o)
    else $error("out-of-range result has payload");

  // A hit neither loads nor evicts.
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_HIT) |-> (loaded_frame_o == '0) && !evict_valid_o)
    else $error("hit reports a fault action");

  // Eviction only on a fault, and a write-back only with an eviction.
  a_evict_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (evict_valid_o || writeback_needed_o) |->
      (status_o == ST_FAULT) && evict_valid_o && (physical_address_o == '0))
    else $error("eviction outside a fault");

endmodule

bind demand_paging_lru_translate dplru_checker u_dplru_checker (.*);
